>>> design/anf_pkg.sv
// Package for the advertising-report local-name filter.
// Holds the AD type codes, parser phase encoding, register indexes and defaults.
// No dependencies.
package anf_pkg;

   // Default size of the name buffer; at most NAME_BUF-1 name bytes are kept
   localparam int NAME_BUF_DEFAULT = 16;

   // AD structure types that carry a local name
   localparam logic [7:0] AD_TYPE_SHORT_NAME    = 8'h08;
   localparam logic [7:0] AD_TYPE_COMPLETE_NAME = 8'h09;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LEN  = 2'd2;

   localparam int CSR_DATA_W   = 64;
   localparam int TARGET_LOW_W  = 64;
   localparam int TARGET_HIGH_W = 56;
   localparam int TARGET_LEN_W  = 4;
   localparam int NAME_LEN_W    = 4;
   localparam int ADDR_W        = 48;

   // Parser phase, one-hot
   typedef enum logic [4:0] {
      PH_LEN  = 5'b00001,
      PH_TYPE = 5'b00010,
      PH_SKIP = 5'b00100,
      PH_NAME = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

endpackage

>>> design/adv_name_filter_core.sv
// Local-name filter for advertising reports: walks the AD structures byte by byte.
// Depends on anf_pkg (type codes, phase encoding, register indexes).
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  data_byte, last_byte, peer_addr
//   rsp_      out        rsp_valid/rsp_stall  name_found, name_matches, name_length, found_addr
//   csr_      in         csr_wr_en            csr_index, csr_wr_data
//
// One report byte is taken per cycle when not stalled; parser state updates in the same cycle.
// The final byte of a report loads the result register; the result outputs come from that register.
// A held result blocks only another final byte; ordinary bytes keep flowing.
// Synchronous active-high reset clears the parser, the targets and the result valid.
module adv_name_filter_core #(
   parameter int NAME_BUF = anf_pkg::NAME_BUF_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_last_byte,
   input  logic [anf_pkg::ADDR_W-1:0]         req_peer_addr,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_name_found,
   output logic                               rsp_name_matches,
   output logic [anf_pkg::NAME_LEN_W-1:0]     rsp_name_length,
   output logic [anf_pkg::ADDR_W-1:0]         rsp_found_addr,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [anf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [anf_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int KW = (NAME_BUF > 2) ? $clog2(NAME_BUF) : 1;
   localparam int LW = (KW > anf_pkg::NAME_LEN_W) ? KW : anf_pkg::NAME_LEN_W;
   localparam logic [KW-1:0] KEPT_MAX = KW'(NAME_BUF - 1);

   // configuration registers
   logic [anf_pkg::TARGET_LOW_W-1:0]  target_low_ff;
   logic [anf_pkg::TARGET_HIGH_W-1:0] target_high_ff;
   logic [anf_pkg::TARGET_LEN_W-1:0]  target_len_ff;

   // parser state
   anf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         bytes_left_ff, bytes_left_in;
   logic [KW-1:0]      kept_count_ff, kept_count_in;
   logic               compare_ok_ff, compare_ok_in;
   logic               found_flag_ff, found_flag_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           found_ff;
   logic                           matches_ff;
   logic [anf_pkg::NAME_LEN_W-1:0] length_ff;
   logic [anf_pkg::ADDR_W-1:0]     addr_ff;

   logic           req_take;
   logic           take_last;
   logic           take_body;
   logic [LW-1:0]  kept_ext;
   logic [LW-1:0]  tlen_ext;
   logic [127:0]   target_all;
   logic [7:0]     target_byte;
   logic           name_match;

   // only a final byte needs the result register
   assign req_stall = rsp_valid_ff & rsp_stall & req_last_byte;
   assign req_take  = req_valid & ~req_stall;
   assign take_last = req_take & req_last_byte;
   assign take_body = req_take & ~req_last_byte;

   assign kept_ext    = LW'(kept_count_ff);
   assign tlen_ext    = LW'(target_len_ff);
   assign target_all  = {8'h00, target_high_ff, target_low_ff};
   assign target_byte = target_all[kept_ext[3:0]*8 +: 8];
   assign name_match  = found_flag_ff & compare_ok_ff & (kept_ext >= tlen_ext);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_low_ff  <= '0;
         target_high_ff <= '0;
         target_len_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            anf_pkg::CSR_TARGET_LOW:  target_low_ff  <= csr_wr_data[anf_pkg::TARGET_LOW_W-1:0];
            anf_pkg::CSR_TARGET_HIGH: target_high_ff <= csr_wr_data[anf_pkg::TARGET_HIGH_W-1:0];
            anf_pkg::CSR_TARGET_LEN:  target_len_ff  <= csr_wr_data[anf_pkg::TARGET_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // parser next state for one report byte
   always_comb begin
      logic [7:0] left_dec;
      left_dec      = bytes_left_ff - 8'd1;
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      kept_count_in = kept_count_ff;
      compare_ok_in = compare_ok_ff;
      found_flag_in = found_flag_ff;
      if (take_last) begin
         phase_in      = anf_pkg::PH_LEN;
         bytes_left_in = '0;
         kept_count_in = '0;
         compare_ok_in = 1'b1;
         found_flag_in = 1'b0;
      end else if (take_body) begin
         case (phase_ff)
            anf_pkg::PH_LEN: begin
               if (req_data_byte == 8'd0) begin
                  phase_in = anf_pkg::PH_DONE;
               end else begin
                  bytes_left_in = req_data_byte;
                  phase_in      = anf_pkg::PH_TYPE;
               end
            end
            anf_pkg::PH_TYPE: begin
               bytes_left_in = left_dec;
               if (req_data_byte == anf_pkg::AD_TYPE_SHORT_NAME ||
                   req_data_byte == anf_pkg::AD_TYPE_COMPLETE_NAME) begin
                  found_flag_in = 1'b1;
                  kept_count_in = '0;
                  compare_ok_in = 1'b1;
                  phase_in = (left_dec != 8'd0) ? anf_pkg::PH_NAME : anf_pkg::PH_DONE;
               end else begin
                  phase_in = (left_dec != 8'd0) ? anf_pkg::PH_SKIP : anf_pkg::PH_LEN;
               end
            end
            anf_pkg::PH_SKIP: begin
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) phase_in = anf_pkg::PH_LEN;
            end
            anf_pkg::PH_NAME: begin
               // keep and compare while the buffer has room
               if (kept_count_ff < KEPT_MAX) begin
                  if (kept_ext < tlen_ext && req_data_byte != target_byte)
                     compare_ok_in = 1'b0;
                  kept_count_in = kept_count_ff + KW'(1);
               end
               bytes_left_in = left_dec;
               if (left_dec == 8'd0) phase_in = anf_pkg::PH_DONE;
            end
            default: ;
         endcase
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= anf_pkg::PH_LEN;
         bytes_left_ff <= '0;
         kept_count_ff <= '0;
         compare_ok_ff <= 1'b1;
         found_flag_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         kept_count_ff <= kept_count_in;
         compare_ok_ff <= compare_ok_in;
         found_flag_ff <= found_flag_in;
      end
   end

   // result register: loaded by the final byte, held while stalled
   assign rsp_valid_in = take_last | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_last) begin
         found_ff   <= found_flag_ff;
         matches_ff <= name_match;
         length_ff  <= found_flag_ff ? kept_ext[anf_pkg::NAME_LEN_W-1:0] : '0;
         addr_ff    <= name_match ? req_peer_addr : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_name_found   = found_ff;
   assign rsp_name_matches = matches_ff;
   assign rsp_name_length  = length_ff;
   assign rsp_found_addr   = addr_ff;

   // checks
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      take_last |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   a_kept_bounded: assert property (@(posedge clock) disable iff (reset)
      kept_count_ff <= KEPT_MAX)
      else $error("kept name count beyond buffer");

   a_name_needs_found: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == anf_pkg::PH_NAME) |-> (found_flag_ff && bytes_left_ff != 8'd0))
      else $error("name phase without a found name structure");

   a_no_name_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (!matches_ff && length_ff == '0))
      else $error("result without name carries length or match");

   a_addr_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !matches_ff) |-> (addr_ff == '0))
      else $error("address reported without a match");

endmodule
